// ===== rtl/sslim_pkg.sv =====
// shared types, widths and helpers for the six axis setpoint slew limiter
// used by sslim_axis and six_axis_setpoint_slew_limiter; no dependencies
package sslim_pkg;

  localparam int POS_WIDTH = 32;
  localparam int AXES      = 6;
  localparam int FIELD_W   = 32;
  localparam int STEP_W    = 31;
  localparam int CFG_IDX_W = 3;
  localparam int TDATA_W   = AXES * FIELD_W;

  localparam int EXT_W  = ((POS_WIDTH > FIELD_W) ? POS_WIDTH : FIELD_W) + 1;
  localparam int DIFF_W = ((POS_WIDTH > STEP_W) ? POS_WIDTH : STEP_W) + 2;

  typedef logic signed [POS_WIDTH-1:0] pos_t;
  typedef logic signed [FIELD_W-1:0]   field_t;
  typedef logic        [STEP_W-1:0]    step_t;
  typedef logic signed [EXT_W-1:0]     ext_t;
  typedef logic signed [DIFF_W-1:0]    diff_t;

  localparam int AX_ROLL  = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_HEAVE = 2;
  localparam int AX_SURGE = 3;
  localparam int AX_YAW   = 4;
  localparam int AX_SWAY  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTH     = 3'd0,
    REG_STEP_ROLL  = 3'd1,
    REG_STEP_PITCH = 3'd2,
    REG_STEP_HEAVE = 3'd3,
    REG_STEP_SURGE = 3'd4,
    REG_STEP_YAW   = 3'd5,
    REG_STEP_SWAY  = 3'd6
  } cfg_reg_e;

  localparam ext_t POS_MAX_X = ext_t'((ext_t'(1) <<< (POS_WIDTH - 1)) - ext_t'(1));
  localparam ext_t POS_MIN_X = -POS_MAX_X - ext_t'(1);
  localparam ext_t F32_MAX_X = ext_t'((ext_t'(1) <<< (FIELD_W - 1)) - ext_t'(1));
  localparam ext_t F32_MIN_X = -F32_MAX_X - ext_t'(1);

  // saturate an incoming target into the position range
  function automatic pos_t clamp_pos(field_t v);
    ext_t x;
    ext_t r;
    x = ext_t'(v);
    if (x > POS_MAX_X) begin
      r = POS_MAX_X;
    end else if (x < POS_MIN_X) begin
      r = POS_MIN_X;
    end else begin
      r = x;
    end
    return pos_t'(r);
  endfunction

  // saturate a position into the output field range
  function automatic field_t sat_out(pos_t v);
    ext_t x;
    ext_t r;
    x = ext_t'(v);
    if (x > F32_MAX_X) begin
      r = F32_MAX_X;
    end else if (x < F32_MIN_X) begin
      r = F32_MIN_X;
    end else begin
      r = x;
    end
    return field_t'(r);
  endfunction

endpackage

// ===== rtl/sslim_axis.sv =====
// one axis compare-and-step unit: moves toward the goal by at most the step, or
// jumps to it with smoothing off; depends on sslim_pkg
module sslim_axis (
  input  sslim_pkg::pos_t  cur_i,
  input  sslim_pkg::pos_t  goal_i,
  input  sslim_pkg::step_t step_i,
  input  logic             smooth_i,
  output sslim_pkg::pos_t  next_o
);
  import sslim_pkg::*;

  diff_t cur_x;
  diff_t diff;
  diff_t gap;
  diff_t step_x;
  diff_t stepped;

  always_comb begin
    cur_x   = diff_t'(cur_i);
    diff    = diff_t'(goal_i) - cur_x;
    gap     = diff[DIFF_W-1] ? -diff : diff;
    step_x  = diff_t'(step_i);
    stepped = diff[DIFF_W-1] ? (cur_x - step_x) : (cur_x + step_x);
    if (!smooth_i) begin
      next_o = goal_i;
    end else if (gap > step_x) begin
      next_o = pos_t'(stepped);
    end else begin
      next_o = goal_i;
    end
  end

endmodule

// ===== rtl/six_axis_setpoint_slew_limiter.sv =====
// top level of the six axis setpoint slew limiter: config registers, goal and
// position state, output register; depends on sslim_pkg and sslim_axis
//
// Returns one result transfer for each setpoint transfer, in order. With tuser
// high the six targets become the new goal; then every axis either jumps to its
// goal (smoothing off) or moves toward it by at most its step and lands on it
// once the gap is within the step (smoothing on). Values are signed Q16.16. The
// goal/position update and compare-and-step of all six axes are combinational
// and the result is registered, so it appears in the cycle after its input
// transfer; the output register lets a new input transfer be taken in the same
// cycle a waiting result is taken, so throughput is one item per clock while
// m_axis_tready is high. Configuration writes take effect on the next transfer.
module six_axis_setpoint_slew_limiter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sslim_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sslim_pkg::STEP_W-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // target_roll, target_pitch, target_heave, target_surge, target_yaw, target_sway
  input  logic [sslim_pkg::TDATA_W-1:0]   s_axis_tdata,
  // load_target
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_roll, out_pitch, out_heave, out_surge, out_yaw, out_sway
  output logic [sslim_pkg::TDATA_W-1:0]   m_axis_tdata
);
  import sslim_pkg::*;

  logic   smooth_q;
  step_t  step_q [AXES];
  pos_t   goal_q [AXES];
  pos_t   goal_d [AXES];
  pos_t   cur_q  [AXES];
  pos_t   cur_d  [AXES];
  logic   out_valid_q;
  logic [TDATA_W-1:0] out_q;
  logic [TDATA_W-1:0] out_d;
  logic   in_xfer;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        step_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SMOOTH:     smooth_q         <= cfg_data_i[0];
        REG_STEP_ROLL:  step_q[AX_ROLL]  <= cfg_data_i;
        REG_STEP_PITCH: step_q[AX_PITCH] <= cfg_data_i;
        REG_STEP_HEAVE: step_q[AX_HEAVE] <= cfg_data_i;
        REG_STEP_SURGE: step_q[AX_SURGE] <= cfg_data_i;
        REG_STEP_YAW:   step_q[AX_YAW]   <= cfg_data_i;
        REG_STEP_SWAY:  step_q[AX_SWAY]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_axis
    assign goal_d[g] = s_axis_tuser
                       ? clamp_pos(field_t'(s_axis_tdata[g*FIELD_W +: FIELD_W]))
                       : goal_q[g];

    sslim_axis u_axis (
      .cur_i    (cur_q[g]),
      .goal_i   (goal_d[g]),
      .step_i   (step_q[g]),
      .smooth_i (smooth_q),
      .next_o   (cur_d[g])
    );

    assign out_d[g*FIELD_W +: FIELD_W] = sat_out(cur_d[g]);
  end

  // goal and position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        goal_q[a] <= '0;
        cur_q[a]  <= '0;
      end
    end else if (in_xfer) begin
      for (int a = 0; a < AXES; a++) begin
        goal_q[a] <= goal_d[a];
        cur_q[a]  <= cur_d[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

endmodule
